### hw/rtl/tcpr_pkg.sv
// Shared types, constants and the palette function for the text cell pixel renderer.
// Used by every module under hw/rtl; it depends on nothing else.
`default_nettype none

package tcpr_pkg;

    // Default screen size in pixels, used as top-level parameter defaults.
    localparam int SCREEN_WIDTH_DEF  = 640;
    localparam int SCREEN_HEIGHT_DEF = 480;

    // Cell geometry.
    localparam int CELL_W = 8;
    localparam int CELL_H = 16;

    // Width used for the centring arithmetic; it covers screens up to 4096 pixels.
    localparam int CALC_W = 13;

    // Configuration port widths.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Reset values of the configuration registers.
    localparam logic [4:0] ROWS_RESET    = 5'd30;
    localparam logic [6:0] COLUMNS_RESET = 7'd80;

    // Pixel format codes.
    localparam logic FORMAT_RGB565   = 1'b0;
    localparam logic FORMAT_XRGB8888 = 1'b1;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_ROWS      = 3'd0,
        REG_COLUMNS   = 3'd1,
        REG_CURSOR_X  = 3'd2,
        REG_CURSOR_Y  = 3'd3,
        REG_CURSOR_ON = 3'd4,
        REG_FORMAT    = 3'd5
    } reg_idx_t;

    // One input transaction: a slice of a text cell.
    typedef struct packed {
        logic [4:0] cell_row;
        logic [6:0] cell_column;
        logic [3:0] glyph_line;
        logic [7:0] attribute;
        logic [7:0] glyph_bits;
    } cell_t;

    // One result transaction: a single pixel.
    typedef struct packed {
        logic [9:0]  pixel_x;
        logic [8:0]  pixel_y;
        logic [23:0] color;
        logic        last;
    } pixel_t;

    // Settings derived from the configuration registers.
    typedef struct packed {
        logic [9:0] x_off;
        logic [8:0] y_off;
        logic [7:0] cursor_column;
        logic [7:0] cursor_row;
        logic       cursor_on;
        logic       pixel_format;
    } cfg_t;

    // A decoded slice, ready for pixel emission.
    typedef struct packed {
        logic [9:0]  px_base;
        logic [8:0]  py;
        logic [23:0] fg;
        logic [23:0] bg;
        logic [7:0]  glyph_bits;
    } slice_t;

    // Sixteen-entry VGA palette in xrgb8888.
    function automatic logic [23:0] vga_palette(input logic [3:0] idx);
        logic [23:0] c;
        unique case (idx)
            4'd0:    c = 24'h000000;
            4'd1:    c = 24'h0000aa;
            4'd2:    c = 24'h00aa00;
            4'd3:    c = 24'h00aaaa;
            4'd4:    c = 24'haa0000;
            4'd5:    c = 24'haa00aa;
            4'd6:    c = 24'haa5500;
            4'd7:    c = 24'haaaaaa;
            4'd8:    c = 24'h555555;
            4'd9:    c = 24'h5555ff;
            4'd10:   c = 24'h55ff55;
            4'd11:   c = 24'h55ffff;
            4'd12:   c = 24'hff5555;
            4'd13:   c = 24'hff55ff;
            4'd14:   c = 24'hffff55;
            default: c = 24'hffffff;
        endcase
        return c;
    endfunction

    // Truncating conversion to 5:6:5, placed in the low 16 bits.
    function automatic logic [23:0] to_rgb565(input logic [23:0] c);
        return {8'h00, c[23:19], c[15:10], c[7:3]};
    endfunction

endpackage

`default_nettype wire

### hw/rtl/tcpr_cfg.sv
// Configuration registers behind the APB-style port, and the centring offsets.
// Depends on tcpr_pkg.
`default_nettype none

module tcpr_cfg #(
    parameter int SCREEN_WIDTH  = tcpr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tcpr_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tcpr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [tcpr_pkg::DATA_W-1:0] pwdata,
    output logic      [tcpr_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output tcpr_pkg::cfg_t                   cfg
);
    import tcpr_pkg::*;

    localparam logic [CALC_W-1:0] FITS_X = CALC_W'(SCREEN_WIDTH / CELL_W);
    localparam logic [CALC_W-1:0] FITS_Y = CALC_W'(SCREEN_HEIGHT / CELL_H);

    logic [4:0] rows_reg;
    logic [6:0] columns_reg;
    logic [7:0] cursor_column_reg;
    logic [7:0] cursor_row_reg;
    logic       cursor_on_reg;
    logic       pixel_format_reg;

    logic           wr_en;
    reg_idx_t       idx;
    logic [CALC_W-1:0] used_x;
    logic [CALC_W-1:0] used_y;
    logic [CALC_W-1:0] span_x;
    logic [CALC_W-1:0] span_y;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[4:2]);

    // Register writes on the access phase of a write transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg          <= ROWS_RESET;
            columns_reg       <= COLUMNS_RESET;
            cursor_column_reg <= 8'd0;
            cursor_row_reg    <= 8'd0;
            cursor_on_reg     <= 1'b1;
            pixel_format_reg  <= FORMAT_RGB565;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_ROWS:      rows_reg          <= pwdata[4:0];
                REG_COLUMNS:   columns_reg       <= pwdata[6:0];
                REG_CURSOR_X:  cursor_column_reg <= pwdata[7:0];
                REG_CURSOR_Y:  cursor_row_reg    <= pwdata[7:0];
                REG_CURSOR_ON: cursor_on_reg     <= pwdata[0];
                REG_FORMAT:    pixel_format_reg  <= pwdata[0];
                default:       ;
            endcase
        end
    end

    // Read data for the addressed register.
    always_comb
    begin
        unique case (idx)
            REG_ROWS:      prdata = DATA_W'(rows_reg);
            REG_COLUMNS:   prdata = DATA_W'(columns_reg);
            REG_CURSOR_X:  prdata = DATA_W'(cursor_column_reg);
            REG_CURSOR_Y:  prdata = DATA_W'(cursor_row_reg);
            REG_CURSOR_ON: prdata = DATA_W'(cursor_on_reg);
            REG_FORMAT:    prdata = DATA_W'(pixel_format_reg);
            default:       prdata = '0;
        endcase
    end

    // Centring offsets: half the unused cells, saturating at zero when too many are shown.
    assign used_x = CALC_W'(columns_reg);
    assign used_y = CALC_W'(rows_reg);
    assign span_x = (used_x >= FITS_X) ? '0 : (FITS_X - used_x);
    assign span_y = (used_y >= FITS_Y) ? '0 : (FITS_Y - used_y);

    always_comb
    begin
        cfg.x_off         = 10'(span_x << 2);
        cfg.y_off         = 9'(span_y << 3);
        cfg.cursor_column = cursor_column_reg;
        cfg.cursor_row    = cursor_row_reg;
        cfg.cursor_on     = cursor_on_reg;
        cfg.pixel_format  = pixel_format_reg;
    end

endmodule

`default_nettype wire

### hw/rtl/tcpr_decode.sv
// Turns an incoming cell slice into base coordinates and the two output colours.
// Depends on tcpr_pkg.
`default_nettype none

module tcpr_decode (
    input  tcpr_pkg::cell_t  cell_slice,
    input  tcpr_pkg::cfg_t   cfg,
    output tcpr_pkg::slice_t slice
);
    import tcpr_pkg::*;

    logic [23:0] fg_raw;
    logic [23:0] bg_raw;
    logic        on_cursor;
    logic [23:0] fg_sel;
    logic [23:0] bg_sel;

    // Palette lookup and cursor swap.
    assign fg_raw    = vga_palette(cell_slice.attribute[3:0]);
    assign bg_raw    = vga_palette({1'b0, cell_slice.attribute[6:4]});
    assign on_cursor = cfg.cursor_on
                       && ({1'b0, cell_slice.cell_column} == cfg.cursor_column)
                       && ({3'b000, cell_slice.cell_row} == cfg.cursor_row);
    assign fg_sel    = on_cursor ? bg_raw : fg_raw;
    assign bg_sel    = on_cursor ? fg_raw : bg_raw;

    // Coordinates wrap to the output widths; colours are put in the output format here.
    always_comb
    begin
        slice.px_base    = cfg.x_off + {cell_slice.cell_column, 3'b000};
        slice.py         = cfg.y_off + {cell_slice.cell_row, 4'b0000}
                           + 9'(cell_slice.glyph_line);
        slice.fg         = (cfg.pixel_format == FORMAT_RGB565) ? to_rgb565(fg_sel) : fg_sel;
        slice.bg         = (cfg.pixel_format == FORMAT_RGB565) ? to_rgb565(bg_sel) : bg_sel;
        slice.glyph_bits = cell_slice.glyph_bits;
    end

endmodule

`default_nettype wire

### hw/rtl/tcpr_emitter.sv
// Slice register, pixel counter and result register: one pixel per clock cycle.
// Depends on tcpr_pkg.
`default_nettype none

module tcpr_emitter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  tcpr_pkg::slice_t slice_in,
    output logic             busy,
    output logic             strobe,
    output tcpr_pkg::pixel_t pixel
);
    import tcpr_pkg::*;

    slice_t     slice_reg;
    logic       active_reg;
    logic       active_next;
    logic [2:0] k_reg;
    logic [2:0] k_next;
    logic       strobe_reg;
    pixel_t     pixel_reg;
    pixel_t     pixel_next;
    logic       lit;

    // Busy until the eighth pixel of the held slice is being formed.
    assign busy = active_reg && (k_reg != 3'd7);

    // Pixel counter and activity flag.
    always_comb
    begin
        active_next = active_reg;
        k_next      = k_reg;
        if (load)
        begin
            active_next = 1'b1;
            k_next      = 3'd0;
        end
        else if (active_reg)
        begin
            k_next = k_reg + 3'd1;
            if (k_reg == 3'd7)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            k_reg      <= 3'd0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            k_reg      <= k_next;
            strobe_reg <= active_reg;
        end
    end

    // Slice payload is taken on each accepted transaction.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slice_reg <= slice_in;
        end
    end

    // Select pixel k of the held slice, leftmost glyph bit first.
    assign lit = slice_reg.glyph_bits[3'd7 - k_reg];

    always_comb
    begin
        pixel_next.pixel_x = slice_reg.px_base + 10'(k_reg);
        pixel_next.pixel_y = slice_reg.py;
        pixel_next.color   = lit ? slice_reg.fg : slice_reg.bg;
        pixel_next.last    = (k_reg == 3'd7);
    end

    always_ff @(posedge clk)
    begin
        pixel_reg <= pixel_next;
    end

    assign strobe = strobe_reg;
    assign pixel  = pixel_reg;

    // A busy emitter must produce a pixel in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n) busy |=> strobe)
        else $error("emitter busy without a following pixel");

    // Pixels of one slice come out without gaps.
    assert property (@(posedge clk) disable iff (!rst_n) (strobe && !pixel.last) |=> strobe)
        else $error("gap inside a slice");

    // Within a slice x steps by one and y holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !pixel.last) |=>
            (pixel.pixel_x == $past(pixel.pixel_x) + 10'd1)
            && (pixel.pixel_y == $past(pixel.pixel_y)))
        else $error("pixel coordinates out of step");

    // An accepted slice is registered, then its first pixel with strobe.
    assert property (@(posedge clk) disable iff (!rst_n) load |-> ##2 strobe)
        else $error("accepted slice produced no pixel");

endmodule

`default_nettype wire

### hw/rtl/text_cell_pixel_renderer.sv
// Top level of the text cell pixel renderer: configuration, slice decode and pixel emission.
// Depends on tcpr_pkg, tcpr_cfg, tcpr_decode and tcpr_emitter.
`default_nettype none

// Each accepted cell slice produces eight pixels on consecutive clock cycles, one per cycle,
// each shown for exactly one cycle with strobe high; the receiver cannot stall and must take
// every pixel as it appears. An accepted slice is registered, then its first pixel is registered
// and shown. A slice occupies the emitter's pixel counter; busy drops in the cycle in which the
// eighth pixel is formed, so a new slice can be accepted then and a steady stream of slices gives
// an unbroken pixel stream at one per cycle. The last flag marks the eighth pixel. The user must
// write configuration through the APB-style port while no slice is in flight (not enforced).
module text_cell_pixel_renderer #(
    parameter int SCREEN_WIDTH  = tcpr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tcpr_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  tcpr_pkg::cell_t                  cell_slice,
    output logic                             strobe,
    output tcpr_pkg::pixel_t                 pixel,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tcpr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [tcpr_pkg::DATA_W-1:0] pwdata,
    output logic      [tcpr_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);
    import tcpr_pkg::*;

    cfg_t   cfg;
    slice_t slice;
    logic   load;

    // A transaction is accepted when start is high and the emitter is not busy.
    assign load = start && !busy;

    tcpr_cfg #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tcpr_decode u_decode (
        .cell_slice (cell_slice),
        .cfg        (cfg),
        .slice      (slice)
    );

    tcpr_emitter u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .slice_in (slice),
        .busy     (busy),
        .strobe   (strobe),
        .pixel    (pixel)
    );

endmodule

`default_nettype wire
